/* design/ttov_pkg.sv */
// ----------------------------------------------------------------------------
// ttov_pkg
// Constants shared by the triangle pair overlap engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttov_pkg;

  localparam int VTX_PER_TRI = 3;
  localparam int NUM_VTX     = 2 * VTX_PER_TRI;
  localparam int NUM_AXES    = 2 * VTX_PER_TRI;

  // edge k of a triangle runs from vertex k to vertex NEXT_VTX[k]
  localparam int NEXT_VTX [VTX_PER_TRI] = '{1, 2, 0};

  // input, edge, product, projection, interval, result registers
  localparam int PIPE_STAGES = 6;

endpackage : ttov_pkg

/* design/triangle_triangle_overlap.sv */
// ----------------------------------------------------------------------------
// triangle_triangle_overlap
// Separating axis overlap test for two 2-D triangles, one pair per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the twelve signed vertex coordinates on in_* and raise start for
//   one cycle per beat. busy is held low: a new pair is taken at every clock
//   edge where start is high, so pairs may follow back to back.
//   Each pair gives exactly one result: out_valid is high for one cycle with
//   out_overlap (1 = overlap or touch, 0 = separated). The receiver cannot
//   stall; results leave in the order the pairs came in.
// Pipeline:
//   One pair per cycle is sustained: six pipeline stages (input, edge
//   vectors, products, projections, min/max intervals, result) each hold
//   one pair, with one multiplier per vertex and axis component in the
//   product stage.
// Reset:
//   rst_n is synchronous and active low. It clears the stage valid bits, so
//   pairs in flight are dropped and no result appears until new pairs arrive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_triangle_overlap
  import ttov_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_a_x0,
  input  logic signed [COORD_BITS-1:0] in_a_y0,
  input  logic signed [COORD_BITS-1:0] in_a_x1,
  input  logic signed [COORD_BITS-1:0] in_a_y1,
  input  logic signed [COORD_BITS-1:0] in_a_x2,
  input  logic signed [COORD_BITS-1:0] in_a_y2,
  input  logic signed [COORD_BITS-1:0] in_b_x0,
  input  logic signed [COORD_BITS-1:0] in_b_y0,
  input  logic signed [COORD_BITS-1:0] in_b_x1,
  input  logic signed [COORD_BITS-1:0] in_b_y1,
  input  logic signed [COORD_BITS-1:0] in_b_x2,
  input  logic signed [COORD_BITS-1:0] in_b_y2,
  output logic                         out_valid,
  output logic                         out_overlap
);

  localparam int CW = COORD_BITS;      // coordinate
  localparam int EW = COORD_BITS + 1;  // edge component
  localparam int PW = EW + CW;         // product
  localparam int SW = PW + 1;          // projection

  // stage valid bits
  logic [PIPE_STAGES-1:0] vld_r;
  logic [PIPE_STAGES-1:0] vld_nxt;

  assign busy    = 1'b0;
  assign vld_nxt = {vld_r[PIPE_STAGES-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[PIPE_STAGES-1];

  // stage 1: input register, vertices 0..2 of a then 0..2 of b
  logic signed [CW-1:0] x_in [NUM_VTX];
  logic signed [CW-1:0] y_in [NUM_VTX];
  logic signed [CW-1:0] x1_r [NUM_VTX];
  logic signed [CW-1:0] y1_r [NUM_VTX];

  always_comb begin
    x_in[0] = in_a_x0;  y_in[0] = in_a_y0;
    x_in[1] = in_a_x1;  y_in[1] = in_a_y1;
    x_in[2] = in_a_x2;  y_in[2] = in_a_y2;
    x_in[3] = in_b_x0;  y_in[3] = in_b_y0;
    x_in[4] = in_b_x1;  y_in[4] = in_b_y1;
    x_in[5] = in_b_x2;  y_in[5] = in_b_y2;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x1_r <= x_in;
      y1_r <= y_in;
    end
  end

  // stage 2 keeps a copy of the vertices for the product stage
  logic signed [CW-1:0] x2_r [NUM_VTX];
  logic signed [CW-1:0] y2_r [NUM_VTX];

  always_ff @(posedge clk) begin
    x2_r <= x1_r;
    y2_r <= y1_r;
  end

  // per axis lanes
  logic [NUM_AXES-1:0] sep_nxt;

  for (genvar j = 0; j < NUM_AXES; j++) begin : g_axis
    localparam int TRI = j / VTX_PER_TRI;
    localparam int K   = j % VTX_PER_TRI;
    localparam int I0  = TRI * VTX_PER_TRI + K;
    localparam int I1  = TRI * VTX_PER_TRI + NEXT_VTX[K];

    // stage 2: axis = (e.y, -e.x) with e = v[k] - v[next]
    logic signed [EW-1:0] ax_nxt, ay_nxt;
    logic signed [EW-1:0] ax_r, ay_r;

    assign ax_nxt = EW'(y1_r[I0]) - EW'(y1_r[I1]);
    assign ay_nxt = EW'(x1_r[I1]) - EW'(x1_r[I0]);

    always_ff @(posedge clk) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
    end

    // lanes 0..2 hold the own triangle, 3..5 the other one
    logic signed [PW-1:0] px_r [NUM_VTX];
    logic signed [PW-1:0] py_r [NUM_VTX];
    logic signed [SW-1:0] pr_r [NUM_VTX];

    for (genvar v = 0; v < NUM_VTX; v++) begin : g_vtx
      localparam int SRC = (v < VTX_PER_TRI) ?
                           (TRI * VTX_PER_TRI + v) :
                           ((1 - TRI) * VTX_PER_TRI + v - VTX_PER_TRI);

      logic signed [PW-1:0] px_nxt, py_nxt;
      logic signed [SW-1:0] pr_nxt;

      // stage 3: products
      assign px_nxt = PW'(ax_r) * PW'(x2_r[SRC]);
      assign py_nxt = PW'(ay_r) * PW'(y2_r[SRC]);

      always_ff @(posedge clk) begin
        px_r[v] <= px_nxt;
        py_r[v] <= py_nxt;
      end

      // stage 4: projection
      assign pr_nxt = SW'(px_r[v]) + SW'(py_r[v]);

      always_ff @(posedge clk) begin
        pr_r[v] <= pr_nxt;
      end
    end

    // stage 5: intervals
    logic signed [SW-1:0] lo1_nxt, hi1_nxt, lo2_nxt, hi2_nxt;
    logic signed [SW-1:0] lo1_r, hi1_r, lo2_r, hi2_r;

    always_comb begin
      lo1_nxt = pr_r[0];
      hi1_nxt = pr_r[0];
      if (pr_r[1] < lo1_nxt) lo1_nxt = pr_r[1];
      if (pr_r[1] > hi1_nxt) hi1_nxt = pr_r[1];
      if (pr_r[2] < lo1_nxt) lo1_nxt = pr_r[2];
      if (pr_r[2] > hi1_nxt) hi1_nxt = pr_r[2];
      lo2_nxt = pr_r[3];
      hi2_nxt = pr_r[3];
      if (pr_r[4] < lo2_nxt) lo2_nxt = pr_r[4];
      if (pr_r[4] > hi2_nxt) hi2_nxt = pr_r[4];
      if (pr_r[5] < lo2_nxt) lo2_nxt = pr_r[5];
      if (pr_r[5] > hi2_nxt) hi2_nxt = pr_r[5];
    end

    always_ff @(posedge clk) begin
      lo1_r <= lo1_nxt;
      hi1_r <= hi1_nxt;
      lo2_r <= lo2_nxt;
      hi2_r <= hi2_nxt;
    end

    // a null axis gives equal zero intervals and never separates
    assign sep_nxt[j] = (hi1_r < lo2_r) || (hi2_r < lo1_r);
  end

  // stage 6: result register
  logic overlap_r;
  logic overlap_nxt;

  assign overlap_nxt = ~|sep_nxt;

  always_ff @(posedge clk) begin
    overlap_r <= overlap_nxt;
  end

  assign out_overlap = overlap_r;

endmodule : triangle_triangle_overlap
